FILE: sv/srfc_pkg.sv
package srfc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_CODE = 8'd3;
    localparam logic [7:0]  DATA_LEN  = 8'd4;
    localparam logic [15:0] SIGN_MASK = 16'h8000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_FUNC = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_CRC_ERR  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        POS_FUNC    = 3'd0,
        POS_LEN     = 3'd1,
        POS_HUM_HI  = 3'd2,
        POS_HUM_LO  = 3'd3,
        POS_TEMP_HI = 3'd4,
        POS_TEMP_LO = 3'd5,
        POS_CRC_LO  = 3'd6,
        POS_CRC_HI  = 3'd7
    } t_pos;

    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/srfc_if.sv
interface srfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface srfc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;

    modport source (output valid, output status, output humidity_tenths,
                    output temperature_tenths, input ready);
    modport sink   (input valid, input status, input humidity_tenths,
                    input temperature_tenths, output ready);
endinterface

FILE: sv/sensor_reply_frame_checker.sv
// Checks an eight-byte sensor reply taken one byte per transfer: a reflected
// CRC-16 (init 0xFFFF, polynomial 0xA001) over bytes 0 to 5 against bytes 6
// and 7, function code 3 in byte 0 and length 4 in byte 1. After byte 7 one
// result is given: status (ok, bad function code, bad length, CRC mismatch,
// first match wins), humidity in tenths and temperature in tenths converted
// from sign-magnitude to two's complement. A frame_start byte restarts the
// frame; without marks the count wraps after byte 7. One byte is taken every
// cycle: each byte passes an input register, then one CRC byte update between
// that register and the frame state. Byte 7 leaving the input register loads
// the result into an output register. While the sink holds a result off,
// bytes keep flowing until the last byte of the next frame, which waits in
// the input register and stalls the input until the result is taken.
module sensor_reply_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srfc_in_if.sink    i_rx,
    srfc_out_if.source o_res
);
    import srfc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    logic [2:0]  r_byte_count;
    logic [15:0] r_crc;
    t_status     r_hdr_err;
    logic [15:0] r_hum_word;
    logic [15:0] r_temp_word;
    logic [7:0]  r_crc_lo;

    logic        r_out_valid;
    t_status     r_out_status;
    logic [15:0] r_out_hum;
    logic [15:0] r_out_temp;

    t_pos        pos;
    logic        has_result;
    logic        advance;
    logic [15:0] crc_next;
    logic [14:0] temp_mag;
    t_status     n_status;
    logic [15:0] n_temp;

    logic [2:0]  n_byte_count;
    logic [15:0] n_crc;
    t_status     n_hdr_err;
    logic [15:0] n_hum_word;
    logic [15:0] n_temp_word;
    logic [7:0]  n_crc_lo;

    assign pos        = r_in_start ? POS_FUNC : t_pos'(r_byte_count);
    assign has_result = (pos == POS_CRC_HI);
    assign advance    = r_in_valid && (!has_result || !r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    assign crc_next = crc_feed((pos == POS_FUNC) ? CRC_INIT : r_crc, r_in_byte);
    assign temp_mag = r_temp_word[14:0];

    always_comb begin
        if (r_hdr_err != ST_OK) begin
            n_status = r_hdr_err;
        end else if (r_crc_lo != r_crc[7:0] || r_in_byte != r_crc[15:8]) begin
            n_status = ST_CRC_ERR;
        end else begin
            n_status = ST_OK;
        end
        if ((r_temp_word & SIGN_MASK) != 16'h0000) begin
            n_temp = 16'h0000 - {1'b0, temp_mag};
        end else begin
            n_temp = {1'b0, temp_mag};
        end
    end

    always_comb begin
        n_byte_count = 3'(pos + 3'd1);
        n_crc        = r_crc;
        n_hdr_err    = r_hdr_err;
        n_hum_word   = r_hum_word;
        n_temp_word  = r_temp_word;
        n_crc_lo     = r_crc_lo;
        unique case (pos)
            POS_FUNC: begin
                n_crc     = crc_next;
                n_hdr_err = (r_in_byte != FUNC_CODE) ? ST_BAD_FUNC : ST_OK;
            end
            POS_LEN: begin
                n_crc = crc_next;
                if (r_hdr_err == ST_OK && r_in_byte != DATA_LEN) begin
                    n_hdr_err = ST_BAD_LEN;
                end
            end
            POS_HUM_HI: begin
                n_crc      = crc_next;
                n_hum_word = {r_in_byte, 8'h00};
            end
            POS_HUM_LO: begin
                n_crc      = crc_next;
                n_hum_word = {r_hum_word[15:8], r_in_byte};
            end
            POS_TEMP_HI: begin
                n_crc       = crc_next;
                n_temp_word = {r_in_byte, 8'h00};
            end
            POS_TEMP_LO: begin
                n_crc       = crc_next;
                n_temp_word = {r_temp_word[15:8], r_in_byte};
            end
            POS_CRC_LO: begin
                n_crc_lo = r_in_byte;
            end
            POS_CRC_HI: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte  <= i_rx.rx_byte;
            r_in_start <= i_rx.frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 3'd0;
            r_crc        <= CRC_INIT;
            r_hdr_err    <= ST_OK;
            r_hum_word   <= 16'h0000;
            r_temp_word  <= 16'h0000;
            r_crc_lo     <= 8'h00;
        end else if (advance) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_hdr_err    <= n_hdr_err;
            r_hum_word   <= n_hum_word;
            r_temp_word  <= n_temp_word;
            r_crc_lo     <= n_crc_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && has_result) begin
            r_out_status <= n_status;
            r_out_hum    <= r_hum_word;
            r_out_temp   <= n_temp;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.status             = r_out_status;
    assign o_res.humidity_tenths    = r_out_hum;
    assign o_res.temperature_tenths = r_out_temp;

`ifndef NO_ASSERTIONS
    a_result_only_on_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && has_result))
        else $error("result loaded without a last frame byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && has_result && r_out_valid && !o_res.ready))
        else $error("pending result overwritten");

    a_start_restarts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_start) |=> (r_byte_count == 3'd1))
        else $error("frame start did not restart the byte count");

    a_start_restarts_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_start) |=> (r_crc == crc_feed(CRC_INIT, $past(r_in_byte))))
        else $error("frame start did not restart the CRC");
`endif

endmodule
